FILE: sv/ddmm_pkg.sv
`timescale 1ns / 1ps

package ddmm_pkg;

    localparam int FRACTION_DIGITS_DEF = 7;
    localparam int SCALE_DIGITS        = 7;

    localparam int ANGLE_W     = 35;
    localparam int DEG_W       = 34;
    localparam int VAL_W       = 30;
    localparam int QUARTER_W   = VAL_W - 2;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 32;
    localparam int QUOT_W      = 24;
    localparam int POS_W       = 3;
    localparam int WEIGHT_W    = 24;
    localparam int PROD_W      = QUARTER_W + RECIP_W;

    // ceil(2^32 / 15), exact for dividends below 2^28
    localparam logic [RECIP_W-1:0]  RECIP_15    = 29'd286331154;
    localparam logic [WEIGHT_W-1:0] ANGLE_SCALE = 24'd10000000;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_E    = 8'h45;
    localparam logic [7:0] CHAR_W    = 8'h57;

    typedef struct packed {
        logic                 status;
        logic                 neg;
        logic [QUARTER_W-1:0] quarter;
        logic [DEG_W-1:0]     deg_scaled;
    } t_parse;

    typedef struct packed {
        logic               status;
        logic               neg;
        logic [QUOT_W-1:0]  quot;
        logic [ANGLE_W-1:0] deg_signed;
    } t_scaled;

    // weight of a fraction digit at a given place, in 1e-7 minute
    function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [2:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            3'd0: w = 24'd1000000;
            3'd1: w = 24'd100000;
            3'd2: w = 24'd10000;
            3'd3: w = 24'd1000;
            3'd4: w = 24'd100;
            3'd5: w = 24'd10;
            3'd6: w = 24'd1;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: sv/ddmm_parser.sv
`timescale 1ns / 1ps

module ddmm_parser
    import ddmm_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [7:0] i_char_code,
    input  logic       i_first_char,
    input  logic       i_is_longitude,
    output logic       o_valid,
    output t_parse     o_parse
);

    // places past the seventh cannot change a truncated 1e-7 degree result
    localparam int EFF_DIGITS = (FRACTION_DIGITS < SCALE_DIGITS) ?
                                FRACTION_DIGITS : SCALE_DIGITS;
    localparam int CNT_W = $clog2(EFF_DIGITS + 1);

    logic             r_in_valid;
    logic [7:0]       r_char;
    logic             r_first;
    logic             r_lon_in;

    logic             r_done;
    logic             r_lon;
    logic [POS_W-1:0] r_pos;
    logic [DEG_W-1:0] r_deg;
    logic [VAL_W-1:0] r_val;
    logic [CNT_W-1:0] r_cnt;

    logic             r_out_valid;
    t_parse           r_parse;

    logic             n_done;
    logic             n_lon;
    logic [POS_W-1:0] n_pos;
    logic [DEG_W-1:0] n_deg;
    logic [VAL_W-1:0] n_val;
    logic [CNT_W-1:0] n_cnt;
    logic             n_out_valid;
    t_parse           n_parse;

    logic             active;
    logic             is_dig;
    logic [3:0]       digit;
    logic             lon;
    logic [POS_W-1:0] pos;
    logic [DEG_W-1:0] deg;
    logic [VAL_W-1:0] val;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] deg_len;
    logic [POS_W-1:0] dot_pos;
    logic [27:0]      dig_unit;
    logic [27:0]      frac_add;
    logic             neg_letter;
    logic             pos_letter;

    // a first word restarts the string with cleared accumulators
    assign lon = r_first ? r_lon_in : r_lon;
    assign pos = r_first ? '0 : r_pos;
    assign deg = r_first ? '0 : r_deg;
    assign val = r_first ? '0 : r_val;
    assign cnt = r_first ? '0 : r_cnt;

    assign active  = r_in_valid && (r_first || !r_done);
    assign is_dig  = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);
    assign digit   = r_char[3:0];
    assign deg_len = lon ? POS_W'(3) : POS_W'(2);
    assign dot_pos = deg_len + POS_W'(2);

    assign dig_unit = 28'(digit) * 28'(ANGLE_SCALE);
    assign frac_add = 28'(digit) * 28'(frac_weight(3'(cnt)));

    assign neg_letter = lon ? (r_char == CHAR_W) : (r_char == CHAR_S);
    assign pos_letter = lon ? (r_char == CHAR_E) : (r_char == CHAR_N);

    always_comb begin
        n_done      = r_first ? 1'b0 : r_done;
        n_lon       = lon;
        n_pos       = pos;
        n_deg       = deg;
        n_val       = val;
        n_cnt       = cnt;
        n_out_valid = 1'b0;
        n_parse     = '0;
        if (active) begin
            if (pos < deg_len) begin
                if (is_dig) begin
                    n_deg = (deg << 3) + (deg << 1) + DEG_W'(dig_unit);
                    n_pos = pos + POS_W'(1);
                end else begin
                    n_out_valid    = 1'b1;
                    n_parse.status = 1'b1;
                    n_done         = 1'b1;
                end
            end else if (pos < dot_pos) begin
                if (is_dig) begin
                    n_val = (val << 3) + (val << 1) + VAL_W'(dig_unit);
                    n_pos = pos + POS_W'(1);
                end else begin
                    n_out_valid    = 1'b1;
                    n_parse.status = 1'b1;
                    n_done         = 1'b1;
                end
            end else if (pos == dot_pos) begin
                if (r_char == CHAR_DOT) begin
                    n_pos = pos + POS_W'(1);
                end else begin
                    n_out_valid    = 1'b1;
                    n_parse.status = 1'b1;
                    n_done         = 1'b1;
                end
            end else if (is_dig) begin
                if (cnt < CNT_W'(EFF_DIGITS)) begin
                    n_val = val + VAL_W'(frac_add);
                    n_cnt = cnt + CNT_W'(1);
                end
            end else if (neg_letter || pos_letter) begin
                n_out_valid        = 1'b1;
                n_parse.status     = 1'b0;
                n_parse.neg        = neg_letter;
                n_parse.quarter    = val[VAL_W-1:2];
                n_parse.deg_scaled = deg;
                n_done             = 1'b1;
            end else begin
                n_out_valid    = 1'b1;
                n_parse.status = 1'b1;
                n_done         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b1;
            r_lon       <= 1'b0;
            r_pos       <= '0;
            r_deg       <= '0;
            r_val       <= '0;
            r_cnt       <= '0;
        end else if (i_en) begin
            r_in_valid  <= i_valid;
            r_out_valid <= n_out_valid;
            if (r_in_valid) begin
                r_done <= n_done;
                r_lon  <= n_lon;
                r_pos  <= n_pos;
                r_deg  <= n_deg;
                r_val  <= n_val;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_char   <= i_char_code;
            r_first  <= i_first_char;
            r_lon_in <= i_is_longitude;
            r_parse  <= n_parse;
        end
    end

    assign o_valid = r_out_valid;
    assign o_parse = r_parse;

endmodule

FILE: sv/ddmm_scaler.sv
`timescale 1ns / 1ps

module ddmm_scaler
    import ddmm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_parse  i_parse,
    output logic    o_valid,
    output t_scaled o_scaled
);

    logic              r_valid;
    t_scaled           r_scaled;
    t_scaled           n_scaled;
    logic [PROD_W-1:0] prod;
    logic [ANGLE_W-1:0] deg_ext;

    // minutes over sixty: quarter the value, then multiply by the reciprocal of 15
    assign prod    = PROD_W'(i_parse.quarter) * PROD_W'(RECIP_15);
    assign deg_ext = ANGLE_W'(i_parse.deg_scaled);

    always_comb begin
        n_scaled.status     = i_parse.status;
        n_scaled.neg        = i_parse.neg;
        n_scaled.quot       = prod[RECIP_SHIFT +: QUOT_W];
        n_scaled.deg_signed = i_parse.neg ? (~deg_ext + ANGLE_W'(1)) : deg_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled <= n_scaled;
        end
    end

    assign o_valid  = r_valid;
    assign o_scaled = r_scaled;

endmodule

FILE: sv/ddmm_out_buf.sv
`timescale 1ns / 1ps

module ddmm_out_buf
    import ddmm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_scaled            i_scaled,
    input  logic               i_stall,
    output logic               o_en,
    output logic               o_valid,
    output logic               o_status,
    output logic [ANGLE_W-1:0] o_angle
);

    logic               r_out_valid;
    logic               r_out_status;
    logic [ANGLE_W-1:0] r_out_angle;
    logic               r_skid_valid;
    logic               r_skid_status;
    logic [ANGLE_W-1:0] r_skid_angle;

    logic               take;
    logic [ANGLE_W-1:0] quot_ext;
    logic [ANGLE_W-1:0] angle;

    assign take     = r_out_valid && !i_stall;
    assign quot_ext = ANGLE_W'(i_scaled.quot);

    // -(d + q) is formed as (-d) - q
    always_comb begin
        if (i_scaled.status) begin
            angle = '0;
        end else if (i_scaled.neg) begin
            angle = i_scaled.deg_signed - quot_ext;
        end else begin
            angle = i_scaled.deg_signed + quot_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_status <= r_skid_status;
                r_out_angle  <= r_skid_angle;
            end
        end else if (i_valid) begin
            if (!r_out_valid || take) begin
                r_out_status <= i_scaled.status;
                r_out_angle  <= angle;
            end else begin
                r_skid_status <= i_scaled.status;
                r_skid_angle  <= angle;
            end
        end
    end

    // the pipe moves whenever the skid word is free
    assign o_en     = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_angle  = r_out_angle;

endmodule

FILE: sv/ddmm_coordinate_parser_top.sv
// a result word leaves once the hemisphere or bad character has passed the input, parse, divide and output registers
// throughput: one character word per cycle while o_stall is low; o_stall rises only while the skid word is full
// the pipe (input register, parse, divide by 60, sign and sum) freezes while o_stall is high
// reset: synchronous, active low; clears the pipe and waits for a first character
`timescale 1ns / 1ps

module ddmm_coordinate_parser_top
    import ddmm_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_first_char,
    input  logic               i_is_longitude,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic [ANGLE_W-1:0] o_angle
);

    logic    en;
    logic    parse_valid;
    t_parse  parse;
    logic    scaled_valid;
    t_scaled scaled;

    ddmm_parser #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_char_code    (i_char_code),
        .i_first_char   (i_first_char),
        .i_is_longitude (i_is_longitude),
        .o_valid        (parse_valid),
        .o_parse        (parse)
    );

    ddmm_scaler u_scaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (parse_valid),
        .i_parse  (parse),
        .o_valid  (scaled_valid),
        .o_scaled (scaled)
    );

    ddmm_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scaled_valid),
        .i_scaled (scaled),
        .i_stall  (i_stall),
        .o_en     (en),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_angle  (o_angle)
    );

    assign o_stall = !en;

endmodule

FILE: sv/ddmm_checker.sv
`timescale 1ns / 1ps

module ddmm_checker
    import ddmm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_status,
    input logic [ANGLE_W-1:0] o_angle
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_angle))
        else $error("result word changed while stalled");

    // an error word carries a zero angle
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_angle == '0)
        else $error("error word with non-zero angle");

    // the skid word only fills behind a stalled result
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // angle magnitude stays within 1010 degrees (in 1e-7 degree), which covers every three-digit degree field
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |->
            $signed(o_angle) <= 35'sd10100000000 && $signed(o_angle) >= -35'sd10100000000)
        else $error("angle out of range");

endmodule

bind ddmm_coordinate_parser_top ddmm_checker u_ddmm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_status (o_status),
    .o_angle  (o_angle)
);
